[hw/rtl/bfhs_pkg.sv]
// Shared types and constants for the back/forward history stacks.
package bfhs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TAG_W         = 32;
   localparam int SCROLL_W      = 32;
   localparam int ENTRY_W       = TAG_W + SCROLL_W;
   localparam int ACTION_W      = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NAVIGATE  = 3'd0,
      ACT_POP_BACK  = 3'd1,
      ACT_POP_FWD   = 3'd2,
      ACT_PUSH_FWD  = 3'd3,
      ACT_PUSH_BACK = 3'd4
   } action_type;

   // One operation on a ring stack for the current word.
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } ring_op_type;

endpackage

[hw/rtl/bfhs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bfhs_ram #(
   parameter int WIDTH = bfhs_pkg::ENTRY_W,
   parameter int DEPTH = bfhs_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bfhs_ring.sv]
// Bounded ring stack: count and oldest pointer plus the entry RAM.
module bfhs_ring #(
   parameter int DEPTH = bfhs_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bfhs_pkg::ring_op_type        op,
   input  logic [bfhs_pkg::ENTRY_W-1:0] wr_data,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         hit,
   output logic [bfhs_pkg::ENTRY_W-1:0] rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [SW-1:0] base_sum;
   logic [SW-1:0] top_sum;
   logic [SW-1:0] next_sum;
   logic [AW:0]   oldest_inc;
   logic [AW-1:0] push_slot;
   logic [AW-1:0] pop_slot;
   logic          full;
   logic          wr_en;

   assign full       = (count_ff == CW'(DEPTH));
   assign hit        = op.pop && (count_ff != '0);
   assign base_sum   = SW'(oldest_ff) + SW'(count_ff);
   assign top_sum    = base_sum - SW'(1);
   assign oldest_inc = {1'b0, oldest_ff} + (AW+1)'(1);

   // Sums stay below twice the depth, so one conditional subtract wraps them.
   assign next_sum  = (base_sum >= SW'(DEPTH)) ? base_sum - SW'(DEPTH) : base_sum;
   assign push_slot = full ? oldest_ff : next_sum[AW-1:0];
   assign pop_slot  = (top_sum >= SW'(DEPTH)) ? AW'(top_sum - SW'(DEPTH))
                                              : top_sum[AW-1:0];
   assign wr_en     = op.push;

   always_comb begin
      count_in  = count_ff;
      oldest_in = oldest_ff;
      if (op.clear) begin
         count_in  = '0;
         oldest_in = '0;
      end else if (op.push) begin
         if (full) begin
            oldest_in = (oldest_inc == (AW+1)'(DEPTH)) ? '0 : oldest_inc[AW-1:0];
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (hit) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
      end
   end

   bfhs_ram #(
      .WIDTH(bfhs_pkg::ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(push_slot),
      .wr_data(wr_data),
      .rd_en  (hit),
      .rd_addr(pop_slot),
      .rd_data(rd_data)
   );

   assign count = count_ff;

endmodule

[hw/rtl/back_forward_history_stacks_top.sv]
// Top level of the back/forward history stacks with stream input and result ports.
//
//   Port group  Dir  tuser             tdata (lowest bits first)
//   req_*       in   action (3)        entry_tag (32), scroll_bits (32)
//   rsp_*       out  found (1)         entry_tag_out (32), scroll_bits_out (32),
//                                      back_depth, forward_depth, zero fill
//
// A word is accepted in every cycle when the result side keeps up; each word gives one
// result word. The stack RAMs have a registered read, so a word first enters the read
// stage as the pointers update and one slot is read or written, then moves on to the
// result register once that register is free or drained. Reset is synchronous and clears both
// stack counts and pointers; stored entries are not cleared. A stalled result holds in
// the result register while one more word can sit in the read stage behind it.
module back_forward_history_stacks_top #(
   parameter int DEPTH = bfhs_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // req_tdata: entry_tag [31:0], scroll_bits [63:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bfhs_pkg::ENTRY_W-1:0]     req_tdata,
   // req_tuser: action [2:0]
   input  logic [bfhs_pkg::ACTION_W-1:0]    req_tuser,
   // rsp_tdata: entry_tag_out, scroll_bits_out, back_depth, forward_depth, zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [((bfhs_pkg::ENTRY_W + 2*$clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // rsp_tuser: found [0]
   output logic                             rsp_tuser
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int PAY_W  = bfhs_pkg::ENTRY_W + 2*CW;
   localparam int DATA_W = ((PAY_W + 7) / 8) * 8;

   bfhs_pkg::ring_op_type back_op, fwd_op;
   bfhs_pkg::action_type  action;

   logic [CW-1:0]                back_count, fwd_count;
   logic                         back_hit, fwd_hit;
   logic [bfhs_pkg::ENTRY_W-1:0] back_rd, fwd_rd;
   logic [bfhs_pkg::ENTRY_W-1:0] push_entry;
   logic                         req_accept;
   logic                         s1_move;
   logic                         found;

   // Read stage: the word that was just applied to the stacks.
   logic s1_valid_ff, s1_valid_in;
   logic s1_found_ff;
   logic s1_popped_ff;
   logic s1_from_fwd_ff;

   // Result register.
   logic                         out_valid_ff, out_valid_in;
   logic                         out_found_ff;
   logic [bfhs_pkg::ENTRY_W-1:0] out_entry_ff, out_entry_in;
   logic [CW-1:0]                out_back_ff;
   logic [CW-1:0]                out_fwd_ff;

   assign action     = bfhs_pkg::action_type'(req_tuser);
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   // The tag sits in the high half of a stored entry.
   assign push_entry = {req_tdata[bfhs_pkg::TAG_W-1:0],
                        req_tdata[bfhs_pkg::ENTRY_W-1:bfhs_pkg::TAG_W]};

   always_comb begin
      back_op = '0;
      fwd_op  = '0;
      found   = 1'b0;
      if (req_accept) begin
         case (action)
            bfhs_pkg::ACT_NAVIGATE: begin
               back_op.push = 1'b1;
               fwd_op.clear = 1'b1;
               found        = 1'b1;
            end
            bfhs_pkg::ACT_POP_BACK: begin
               back_op.pop = 1'b1;
               found       = (back_count != '0);
            end
            bfhs_pkg::ACT_POP_FWD: begin
               fwd_op.pop = 1'b1;
               found      = (fwd_count != '0);
            end
            bfhs_pkg::ACT_PUSH_FWD: begin
               fwd_op.push = 1'b1;
               found       = 1'b1;
            end
            bfhs_pkg::ACT_PUSH_BACK: begin
               back_op.push = 1'b1;
               found        = 1'b1;
            end
            default: begin
               found = 1'b0;
            end
         endcase
      end
   end

   bfhs_ring #(.DEPTH(DEPTH)) u_back (
      .clock  (clock),
      .reset  (reset),
      .op     (back_op),
      .wr_data(push_entry),
      .count  (back_count),
      .hit    (back_hit),
      .rd_data(back_rd)
   );

   bfhs_ring #(.DEPTH(DEPTH)) u_fwd (
      .clock  (clock),
      .reset  (reset),
      .op     (fwd_op),
      .wr_data(push_entry),
      .count  (fwd_count),
      .hit    (fwd_hit),
      .rd_data(fwd_rd)
   );

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   // RAM read data is held until the next read, which only starts as the read
   // stage drains, so it is still valid when the word moves on.
   always_comb begin
      out_entry_in = '0;
      if (s1_popped_ff) begin
         out_entry_in = s1_from_fwd_ff ? fwd_rd : back_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_found_ff    <= found;
         s1_popped_ff   <= back_op.pop ? back_hit : fwd_hit && fwd_op.pop;
         s1_from_fwd_ff <= fwd_op.pop;
      end
      // The stack counts always reflect the word in the read stage, since no
      // later word can have been applied while it waits there.
      if (s1_move) begin
         out_found_ff <= s1_found_ff;
         out_entry_ff <= out_entry_in;
         out_back_ff  <= back_count;
         out_fwd_ff   <= fwd_count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = DATA_W'({out_fwd_ff, out_back_ff,
                                out_entry_ff[bfhs_pkg::SCROLL_W-1:0],
                                out_entry_ff[bfhs_pkg::ENTRY_W-1:bfhs_pkg::SCROLL_W]});

`ifndef SYNTHESIS
   a_back_bound: assert property (@(posedge clock) disable iff (reset)
      (back_count <= CW'(DEPTH)) && (fwd_count <= CW'(DEPTH)))
      else $error("stack count beyond depth");

   a_nav_clears_fwd: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == bfhs_pkg::ACT_NAVIGATE)) |=> (fwd_count == '0))
      else $error("navigate left forward entries");

   a_full_push_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == bfhs_pkg::ACT_PUSH_BACK) &&
       (back_count == CW'(DEPTH))) |=> (back_count == CW'(DEPTH)))
      else $error("push onto full back stack changed its count");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == bfhs_pkg::ACT_POP_BACK) && (back_count == '0))
      |=> (back_count == '0) && !s1_found_ff && !s1_popped_ff)
      else $error("empty back pop reported an entry");
`endif

endmodule
